/* rtl/complex_magnitude_isqrt_macros.svh */
// Assertion macros shared by the complex magnitude block.
`ifndef COMPLEX_MAGNITUDE_ISQRT_MACROS_SVH
`define COMPLEX_MAGNITUDE_ISQRT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled in reset.
`define CMI_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define CMI_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`else
`define CMI_ASSERT_IMPL(label, clk, rst, lhs, rhs)
`define CMI_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

/* rtl/cmi_pkg.sv */
// Shared constants and pipeline control type for the complex magnitude block.
package cmi_pkg;

  // Width and saturation value of the magnitude result
  localparam int MAG_W = 16;
  localparam logic [MAG_W-1:0] MAG_MAX = 16'hFFFF;

  // Control handed to the front end and to every root-step stage
  typedef struct packed {
    logic valid;    // item present at the stage input
    logic advance;  // whole pipeline moves this cycle
  } stage_ctl_t;

endpackage

/* rtl/cmi_square.sv */
// Front end: absolute values, squares and sum of squares over three stages.
module cmi_square #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cmi_pkg::stage_ctl_t         ctl,
  input  logic [SAMPLE_WIDTH-1:0]     bin_real,
  input  logic [SAMPLE_WIDTH-1:0]     bin_imag,
  output logic                        sum_valid,
  output logic [2*SAMPLE_WIDTH-1:0]   sum
);

  localparam int SUM_W = 2 * SAMPLE_WIDTH;

  logic                    abs_valid;
  logic [SAMPLE_WIDTH-1:0] abs_real;
  logic [SAMPLE_WIDTH-1:0] abs_imag;
  logic                    sq_valid;
  logic [SUM_W-1:0]        sq_real;
  logic [SUM_W-1:0]        sq_imag;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      abs_valid <= 1'b0;
      sq_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else if (ctl.advance) begin
      abs_valid <= ctl.valid;
      sq_valid  <= abs_valid;
      sum_valid <= sq_valid;
    end
  end

  // Magnitude of each part; the most negative value maps to its unsigned twin
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      abs_real <= bin_real[SAMPLE_WIDTH-1] ? (~bin_real + 1'b1) : bin_real;
      abs_imag <= bin_imag[SAMPLE_WIDTH-1] ? (~bin_imag + 1'b1) : bin_imag;
    end
  end

  // Square each part at full width
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      sq_real <= SUM_W'(abs_real) * SUM_W'(abs_real);
      sq_imag <= SUM_W'(abs_imag) * SUM_W'(abs_imag);
    end
  end

  // Add the squares; the sum never exceeds 2^(SUM_W-1)
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      sum <= sq_real + sq_imag;
    end
  end

endmodule

/* rtl/cmi_sqrt_stage.sv */
// One restoring square-root step: try one root bit and keep the remainder.
module cmi_sqrt_stage #(
  parameter int SUM_W = 32,
  parameter int STEP  = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  cmi_pkg::stage_ctl_t ctl,
  input  logic [SUM_W-1:0]    rem_in,
  input  logic [SUM_W-1:0]    acc_in,
  output logic                valid_out,
  output logic [SUM_W-1:0]    rem_out,
  output logic [SUM_W-1:0]    acc_out
);

  // Trial bit of this step: moves down two positions per step
  localparam logic [SUM_W:0] TRIAL = (SUM_W+1)'(1) << (SUM_W - 2 - 2 * STEP);

  logic [SUM_W:0] probe;
  logic [SUM_W:0] acc_taken;
  logic           take;
  logic [SUM_W:0] rem_taken;

  // Compare remainder against partial root plus trial bit
  always_comb begin
    probe     = {1'b0, acc_in} + TRIAL;
    take      = {1'b0, rem_in} >= probe;
    rem_taken = {1'b0, rem_in} - probe;
    acc_taken = probe + TRIAL;
  end

  // Hold the valid bit with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ctl.advance) begin
      valid_out <= ctl.valid;
    end
  end

  // Accept or reject the bit, then halve the partial root
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      if (take) begin
        rem_out <= rem_taken[SUM_W-1:0];
        acc_out <= acc_taken[SUM_W:1];
      end else begin
        rem_out <= rem_in;
        acc_out <= acc_in >> 1;
      end
    end
  end

endmodule

/* rtl/complex_magnitude_isqrt.sv */
// Throughput: one bin per cycle while the output is not stalled; three front-end
// stages, one root step per stage (SAMPLE_WIDTH steps, each one add and compare), and
// one saturating output stage.
// A stalled output freezes the whole pipeline and stalls the input.
// Reset (rst, synchronous, active high) clears all valid bits; no other state.
// Top level: floor of complex magnitude by pipelined restoring square root.
`include "complex_magnitude_isqrt_macros.svh"

module complex_magnitude_isqrt #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          bin_valid,
  output logic                          bin_stall,
  input  logic [SAMPLE_WIDTH-1:0]       bin_real,
  input  logic [SAMPLE_WIDTH-1:0]       bin_imag,
  output logic                          mag_valid,
  input  logic                          mag_stall,
  output logic [cmi_pkg::MAG_W-1:0]     magnitude
);

  localparam int SUM_W = 2 * SAMPLE_WIDTH;
  localparam int STEPS = SAMPLE_WIDTH;

  logic                 advance;
  logic [STEPS:0]       valid_pipe;
  logic [SUM_W-1:0]     rem_pipe [0:STEPS];
  logic [SUM_W-1:0]     acc_pipe [0:STEPS];
  logic                 saturate;

  // Move everything unless a finished item is held at the output
  assign advance   = !(mag_valid && mag_stall);
  assign bin_stall = !advance;

  // Front end: abs, square, sum
  cmi_square #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_square (
    .clk      (clk),
    .rst      (rst),
    .ctl      ('{valid: bin_valid, advance: advance}),
    .bin_real (bin_real),
    .bin_imag (bin_imag),
    .sum_valid(valid_pipe[0]),
    .sum      (rem_pipe[0])
  );

  assign acc_pipe[0] = '0;

  // Root steps, one per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    cmi_sqrt_stage #(
      .SUM_W(SUM_W),
      .STEP (k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .ctl      ('{valid: valid_pipe[k], advance: advance}),
      .rem_in   (rem_pipe[k]),
      .acc_in   (acc_pipe[k]),
      .valid_out(valid_pipe[k+1]),
      .rem_out  (rem_pipe[k+1]),
      .acc_out  (acc_pipe[k+1])
    );
  end

  // Clamp roots wider than the result field
  assign saturate = 64'(acc_pipe[STEPS]) > 64'(cmi_pkg::MAG_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (advance) begin
      mag_valid <= valid_pipe[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      magnitude <= saturate ? cmi_pkg::MAG_MAX : cmi_pkg::MAG_W'(acc_pipe[STEPS]);
    end
  end

  // An accepted bin shows up in the first front-end stage
  `CMI_ASSERT_NEXT(a_accept_enters, clk, rst, bin_valid && !bin_stall, u_square.abs_valid)
  // A stall freezes the valid bits of the sum and root-step stages
  `CMI_ASSERT_NEXT(a_stall_freezes, clk, rst, !advance, $stable(valid_pipe))
  // Restoring root leaves a remainder no larger than twice the root
  `CMI_ASSERT_IMPL(a_root_remainder, clk, rst, valid_pipe[STEPS],
                   {1'b0, rem_pipe[STEPS]} <= {acc_pipe[STEPS], 1'b0})

endmodule

/* tb/complex_magnitude_isqrt_checker.sv */
// Checker for the complex magnitude block: predicts each magnitude and compares results.
module complex_magnitude_isqrt_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      bin_valid,
  input  logic                      bin_stall,
  input  logic [15:0]               bin_real,
  input  logic [15:0]               bin_imag,
  input  logic                      mag_valid,
  input  logic                      mag_stall,
  input  logic [cmi_pkg::MAG_W-1:0] magnitude,
  output int                        error_count,
  output int                        mag_outstanding
);

  // Highest even power of four that a sum of two 16-bit squares can reach
  localparam logic [31:0] ROOT_BIT_TOP = 32'h4000_0000;

  logic [cmi_pkg::MAG_W-1:0] mag_expected[$];

  // Absolute value of a two's complement sample, as an unsigned 16-bit number
  function automatic logic [15:0] sample_abs(input logic [15:0] s);
    logic [15:0] a;
    a = s[15] ? (~s + 16'd1) : s;
    return a;
  endfunction

  // Floor of the magnitude, by restoring square root of the exact sum of squares
  function automatic logic [cmi_pkg::MAG_W-1:0] floor_magnitude(input logic [15:0] re,
                                                                input logic [15:0] im);
    logic [31:0] re_abs;
    logic [31:0] im_abs;
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] root_bit;
    re_abs   = {16'd0, sample_abs(re)};
    im_abs   = {16'd0, sample_abs(im)};
    rem      = re_abs * re_abs + im_abs * im_abs;
    root     = 32'd0;
    root_bit = ROOT_BIT_TOP;
    while (root_bit > rem) root_bit = root_bit >> 2;
    while (root_bit != 32'd0) begin
      if (rem >= root + root_bit) begin
        rem  = rem - (root + root_bit);
        root = (root >> 1) + root_bit;
      end else begin
        root = root >> 1;
      end
      root_bit = root_bit >> 2;
    end
    // Saturate a root wider than the result field
    if (root > {16'd0, cmi_pkg::MAG_MAX}) root = {16'd0, cmi_pkg::MAG_MAX};
    return root[cmi_pkg::MAG_W-1:0];
  endfunction

  initial begin
    error_count     = 0;
    mag_outstanding = 0;
  end

  // Queue a prediction per accepted bin, then check each accepted magnitude
  always @(posedge clk) begin
    if (!rst) begin
      if (bin_valid && !bin_stall) begin
        mag_expected.push_back(floor_magnitude(bin_real, bin_imag));
      end
      if (mag_valid && !mag_stall) begin
        if (mag_expected.size() == 0) begin
          $display("%0t: unexpected magnitude, expected none, actual %0d", $time, magnitude);
          error_count = error_count + 1;
        end else if (magnitude !== mag_expected[0]) begin
          $display("%0t: magnitude mismatch, expected %0d, actual %0d",
                   $time, mag_expected[0], magnitude);
          error_count = error_count + 1;
          void'(mag_expected.pop_front());
        end else begin
          void'(mag_expected.pop_front());
        end
      end
      mag_outstanding = mag_expected.size();
    end
  end

endmodule

/* tb/complex_magnitude_isqrt_tb.sv */
// Top of the complex magnitude testbench: clock, reset, bin stimulus, result stalls, verdict.
module complex_magnitude_isqrt_tb;

  localparam int RANDOM_BINS    = 1400;
  localparam int HOLD_AT_RESULT = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int IDLE_LIMIT     = 3000;
  localparam int TAIL_CYCLES    = 60;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      bin_valid = 1'b0;
  logic                      bin_stall;
  logic [15:0]               bin_real  = 16'd0;
  logic [15:0]               bin_imag  = 16'd0;
  logic                      mag_valid;
  logic                      mag_stall = 1'b0;
  logic [cmi_pkg::MAG_W-1:0] magnitude;

  int error_count;
  int mag_outstanding;
  int bins_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  complex_magnitude_isqrt dut (
    .clk       (clk),
    .rst       (rst),
    .bin_valid (bin_valid),
    .bin_stall (bin_stall),
    .bin_real  (bin_real),
    .bin_imag  (bin_imag),
    .mag_valid (mag_valid),
    .mag_stall (mag_stall),
    .magnitude (magnitude)
  );

  complex_magnitude_isqrt_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .bin_valid       (bin_valid),
    .bin_stall       (bin_stall),
    .bin_real        (bin_real),
    .bin_imag        (bin_imag),
    .mag_valid       (mag_valid),
    .mag_stall       (mag_stall),
    .magnitude       (magnitude),
    .error_count     (error_count),
    .mag_outstanding (mag_outstanding)
  );

  // Offer one bin after a random gap and hold it until accepted
  task automatic send_bin(input logic [15:0] re, input logic [15:0] im);
    int gap;
    gap = ((bins_sent / 60) % 4 == 2) ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      bin_valid <= 1'b0;
    end
    @(negedge clk);
    bin_valid <= 1'b1;
    bin_real  <= re;
    bin_imag  <= im;
    do @(posedge clk); while (bin_stall);
    bins_sent = bins_sent + 1;
  endtask

  // Draw a sample: mostly full range, some tiny values, some near the extremes
  function automatic logic [15:0] random_sample();
    int pick;
    logic [15:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      s = 16'($urandom());
    end else if (pick < 85) begin
      s = 16'($urandom_range(0, 16) - 8);
    end else if ($urandom_range(0, 1) == 0) begin
      s = 16'h8000 + 16'($urandom_range(0, 3));
    end else begin
      s = 16'h7FFF - 16'($urandom_range(0, 3));
    end
    return s;
  endfunction

  // Stimulus and verdict
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed bins: zero, most negative parts, full scale, small exact roots
    send_bin(16'h0000, 16'h0000);
    send_bin(16'h8000, 16'h8000);
    send_bin(16'h7FFF, 16'h7FFF);
    send_bin(16'h8000, 16'h0000);
    send_bin(16'h0000, 16'h8000);
    send_bin(16'h7FFF, 16'h8000);
    send_bin(16'h8000, 16'h7FFF);
    send_bin(16'h0001, 16'h0000);
    send_bin(16'hFFFF, 16'hFFFF);
    send_bin(16'h0003, 16'hFFFC);
    send_bin(16'hFFFD, 16'h0004);
    send_bin(16'h00FF, 16'h0000);
    send_bin(16'h0100, 16'h0000);
    send_bin(16'h0000, 16'h7FFF);
    send_bin(16'h5555, 16'hAAAA);
    send_bin(16'hAAAA, 16'h5555);
    send_bin(16'h0002, 16'h0002);
    send_bin(16'h0001, 16'h0001);

    // Random bins
    repeat (RANDOM_BINS) send_bin(random_sample(), random_sample());
    @(negedge clk);
    bin_valid <= 1'b0;

    // Drain, then let the pipeline run dry to catch extra results
    while (mag_outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && mag_outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Stall the result side at random, with one long hold to back the block up
  initial begin : result_side
    int results_taken;
    int wait_cycles;
    results_taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (results_taken == HOLD_AT_RESULT) begin
        wait_cycles = HOLD_CYCLES;
      end else if ((results_taken / 50) % 4 == 1) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, 7);
      end
      if (wait_cycles > 0) begin
        @(negedge clk);
        mag_stall <= 1'b1;
        repeat (wait_cycles - 1) @(negedge clk);
        @(negedge clk);
        mag_stall <= 1'b0;
      end
      do @(posedge clk); while (!mag_valid);
      results_taken = results_taken + 1;
    end
  end

  // End the run when nothing moves on either channel for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((bin_valid && !bin_stall) || (mag_valid && !mag_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
    end
    $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
